FILE: design/move_time_profiler_defines.svh
// assertion macros for the move time profiler
`ifndef MOVE_TIME_PROFILER_DEFINES_SVH
`define MOVE_TIME_PROFILER_DEFINES_SVH

// same-cycle implication, checked while out of reset
`define MTP_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, checked while out of reset
`define MTP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: design/mtp_pkg.sv
package mtp_pkg;

	localparam int HIST_DEPTH  = 1024;
	localparam int HIST_AW     = $clog2(HIST_DEPTH);
	localparam int CNT_W       = $clog2(HIST_DEPTH + 1);
	localparam int SUM_W       = 32 + HIST_AW;
	localparam int DIV_CW      = $clog2(SUM_W + 1);
	localparam int RECENT_N    = 50;
	localparam int DEGRADE_MIN = 100;

	localparam logic [1:0] KIND_START    = 2'd0;
	localparam logic [1:0] KIND_COMPLETE = 2'd1;
	localparam logic [1:0] KIND_PREDICT  = 2'd2;
	localparam logic [1:0] KIND_CLEAR    = 2'd3;

	localparam logic [1:0] SRC_PAIR    = 2'd0;
	localparam logic [1:0] SRC_OVERALL = 2'd1;
	localparam logic [1:0] SRC_DEFAULT = 2'd2;

	localparam logic [1:0] CFG_ENABLE = 2'd0;
	localparam logic [1:0] CFG_BASE   = 2'd1;
	localparam logic [1:0] CFG_STEP   = 2'd2;

	localparam logic [15:0] RST_BASE_MS = 16'd1000;
	localparam logic [15:0] RST_STEP_MS = 16'd500;

	typedef struct packed {
		logic [1:0]  kind;
		logic [7:0]  from_slot;
		logic [7:0]  to_slot;
		logic [7:0]  actual_slot;
		logic        move_ok;
		logic [31:0] time_ms;
	} in_t;

	typedef struct packed {
		logic [31:0] predicted_ms;
		logic [1:0]  prediction_source;
		logic        recorded;
		logic        degraded;
		logic [10:0] entries_held;
	} out_t;

	typedef struct packed {
		logic [7:0]  from_slot;
		logic [7:0]  to_slot;
		logic [31:0] duration;
		logic        success;
	} hist_entry_t;

	typedef struct packed {
		logic                we;
		logic [HIST_AW-1:0]  waddr;
		hist_entry_t         wdata;
		logic [HIST_AW-1:0]  raddr;
	} ram_req_t;

	typedef struct packed {
		logic             start;
		logic [SUM_W-1:0] dividend;
		logic [CNT_W-1:0] divisor;
	} div_req_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_WALK,
		ST_PAIR,
		ST_ALL,
		ST_RECENT,
		ST_OUT
	} state_t;

endpackage

FILE: design/mtp_hist_ram.sv
module mtp_hist_ram (
	input  logic                 clk,
	input  mtp_pkg::ram_req_t    req,
	output mtp_pkg::hist_entry_t rdata
);

	mtp_pkg::hist_entry_t mem [mtp_pkg::HIST_DEPTH];
	mtp_pkg::hist_entry_t rdata_q;

	always_ff @(posedge clk) begin
		if (req.we) begin
			mem[req.waddr] <= req.wdata;
		end
		rdata_q <= mem[req.raddr];
	end

	assign rdata = rdata_q;

endmodule

FILE: design/mtp_div.sv
module mtp_div (
	input  logic              clk,
	input  logic              arst_n,
	input  mtp_pkg::div_req_t req,
	output logic              done,
	output logic [31:0]       quotient
);

	// restoring division, one quotient bit per cycle
	logic [mtp_pkg::CNT_W:0]        rem_q;
	logic [mtp_pkg::SUM_W-1:0]      quo_q;
	logic [mtp_pkg::CNT_W-1:0]      dvs_q;
	logic [mtp_pkg::DIV_CW-1:0]     step_q;
	logic                           busy_q;
	logic                           done_q;
	logic [mtp_pkg::CNT_W:0]        trial;
	logic                           fits;

	assign trial = {rem_q[mtp_pkg::CNT_W-1:0], quo_q[mtp_pkg::SUM_W-1]};
	assign fits  = trial >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				step_q <= step_q + 1'b1;
				if (step_q == mtp_pkg::DIV_CW'(mtp_pkg::SUM_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= '0;
			quo_q <= req.dividend;
			dvs_q <= req.divisor;
		end else if (busy_q) begin
			rem_q <= fits ? (trial - {1'b0, dvs_q}) : trial;
			quo_q <= {quo_q[mtp_pkg::SUM_W-2:0], fits};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q[31:0];

endmodule

FILE: design/move_time_profiler.sv
// move time profiler
// requests enter on in_valid / in_stall with an in_t payload: start, complete,
// predict or clear. every request yields one out_t result on out_valid /
// out_stall, held in an output register until taken.
// start, clear, and complete that records nothing or leaves fewer than 100
// entries held are answered with the result registered at the accepting edge.
// predict walks all held entries of the history memory (one read per cycle,
// registered read data) and then runs one or two 42-step serial divisions:
// one for a pair hit, two otherwise.
// complete that records a move and leaves 100 or more entries walks the
// history, runs one division (overall average) and a compare step.
// one request is worked at a time; a new request is taken once the block is
// idle and the output register is free or being emptied.
// cfg_valid / cfg_ready write the three registers (index 0 enable, 1 base,
// 2 step); cfg_ready is always high, writes are expected while idle.
// reset (arst_n low) empties history, drops any pending move, restores
// registers; memory contents stay undefined and are never read unwritten.
// when the receiver stalls, the result holds and the input side stalls.
module move_time_profiler (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_stall,
	input  mtp_pkg::in_t  in_data,
	output logic          out_valid,
	input  logic          out_stall,
	output mtp_pkg::out_t out_data,
	input  logic          cfg_valid,
	output logic          cfg_ready,
	input  logic [1:0]    cfg_index,
	input  logic [15:0]   cfg_data
);

	localparam int AW = mtp_pkg::HIST_AW;
	localparam int CW = mtp_pkg::CNT_W;
	localparam int SW = mtp_pkg::SUM_W;

	// control and config state
	mtp_pkg::state_t state_q, state_d;
	logic            en_q;
	logic [15:0]     base_q;
	logic [15:0]     step_q;
	logic [AW-1:0]   wp_q;
	logic [CW-1:0]   count_q;
	logic            inprog_q;
	logic [31:0]     start_q;
	logic [7:0]      pfrom_q;
	logic [7:0]      pto_q;

	// current request
	logic [1:0]      kind_q;
	logic [7:0]      from_q;
	logic [7:0]      to_q;

	// walk
	logic [CW-1:0]   k_q;
	logic [AW-1:0]   rd_idx_q;
	logic            vld_s1;
	logic            rec_s1;
	logic            issue;

	// accumulators
	logic [SW-1:0]   ov_sum_q;
	logic [CW-1:0]   ov_cnt_q;
	logic [SW-1:0]   pr_sum_q;
	logic [CW-1:0]   pr_cnt_q;
	logic [SW-1:0]   rc_sum_q;
	logic [31:0]     ov_avg_q;
	logic [2:0]      ov_mod5_q;

	// output
	logic            out_valid_q;
	mtp_pkg::out_t   out_q;
	mtp_pkg::out_t   res_q;
	mtp_pkg::out_t   quick_res;
	logic            out_free;
	logic            accept;

	// divider hookup
	mtp_pkg::div_req_t    div_req;
	logic                 div_done;
	logic [31:0]          div_quo;
	logic [31:0]          div_q_m;
	logic                 div_run_q;

	// memory hookup
	mtp_pkg::ram_req_t    ram_req;
	mtp_pkg::hist_entry_t ram_rd;

	// bookkeeping for a completed move
	logic            rec_ok;
	logic [AW-1:0]   wp_next;
	logic [CW-1:0]   cnt_next;
	logic [AW-1:0]   walk_first;
	logic [7:0]      slot_dist;
	logic [31:0]     dflt_ms;

	// degradation threshold
	logic [6:0]      nib_sum;
	logic [4:0]      fold1;
	logic [4:0]      fold2;
	logic [2:0]      ov_mod5;
	logic [SW-1:0]   deg_thr;

	assign out_free  = !out_valid_q || !out_stall;
	assign in_stall  = !((state_q == mtp_pkg::ST_IDLE) && out_free);
	assign accept    = in_valid && !in_stall;
	assign cfg_ready = 1'b1;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	assign rec_ok   = en_q && inprog_q;
	assign wp_next  = (wp_q == AW'(mtp_pkg::HIST_DEPTH - 1)) ? '0 : wp_q + 1'b1;
	assign cnt_next = (count_q < CW'(mtp_pkg::HIST_DEPTH)) ? count_q + 1'b1 : count_q;
	// newest entry of the history as it stands before a predict
	assign walk_first = (wp_q == '0) ? AW'(mtp_pkg::HIST_DEPTH - 1) : wp_q - 1'b1;

	assign slot_dist = (to_q >= from_q) ? to_q - from_q : from_q - to_q;
	assign dflt_ms   = 32'({8'd0, base_q} + (24'(step_q) * 24'(slot_dist)));

	// a zero count gives an average of zero
	assign div_q_m = (div_req.divisor == '0) ? '0 : div_quo;

	// overall average mod 5: nibble weights are 1 mod 5, so fold the nibble sum
	always_comb begin
		nib_sum = '0;
		for (int n = 0; n < 8; n++)
			nib_sum = nib_sum + 7'(div_q_m[4*n +: 4]);
		fold1 = 5'(nib_sum[3:0]) + 5'(nib_sum[6:4]);
		fold2 = 5'(fold1[3:0]) + 5'(fold1[4]);
		if (fold2 >= 5'd15)
			ov_mod5 = 3'(fold2 - 5'd15);
		else if (fold2 >= 5'd10)
			ov_mod5 = 3'(fold2 - 5'd10);
		else if (fold2 >= 5'd5)
			ov_mod5 = 3'(fold2 - 5'd5);
		else
			ov_mod5 = fold2[2:0];
	end

	// floor(recent / 50) * 5 > 6 * overall holds exactly when
	// recent >= 50 * (floor(6 * overall / 5) + 1) = 60 * overall - 10 * (overall mod 5) + 50
	assign deg_thr = SW'({ov_avg_q, 6'b0}) - SW'({ov_avg_q, 2'b0})
		- SW'({ov_mod5_q, 3'b0}) - SW'({ov_mod5_q, 1'b0}) + SW'(mtp_pkg::RECENT_N);

	assign ram_req.we          = accept && (in_data.kind == mtp_pkg::KIND_COMPLETE) && rec_ok;
	assign ram_req.waddr       = wp_q;
	assign ram_req.wdata.from_slot = pfrom_q;
	assign ram_req.wdata.to_slot   = pto_q;
	assign ram_req.wdata.duration  = in_data.time_ms - start_q;
	assign ram_req.wdata.success   = in_data.move_ok && (in_data.actual_slot == pto_q);
	assign ram_req.raddr       = rd_idx_q;

	mtp_hist_ram u_ram (
		.clk   (clk),
		.req   (ram_req),
		.rdata (ram_rd)
	);

	mtp_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (div_req),
		.done     (div_done),
		.quotient (div_quo)
	);

	// next state, walk issue and divider requests
	always_comb begin
		state_d          = state_q;
		issue            = 1'b0;
		div_req.start    = 1'b0;
		div_req.dividend = ov_sum_q;
		div_req.divisor  = ov_cnt_q;
		case (state_q)
			mtp_pkg::ST_IDLE: begin
				if (accept) begin
					case (in_data.kind)
						mtp_pkg::KIND_COMPLETE: begin
							if (rec_ok && cnt_next >= CW'(mtp_pkg::DEGRADE_MIN))
								state_d = mtp_pkg::ST_WALK;
						end
						mtp_pkg::KIND_PREDICT: state_d = mtp_pkg::ST_WALK;
						default: state_d = mtp_pkg::ST_IDLE;
					endcase
				end
			end
			mtp_pkg::ST_WALK: begin
				issue = k_q < count_q;
				if (!issue && !vld_s1)
					state_d = (kind_q == mtp_pkg::KIND_COMPLETE) ?
						mtp_pkg::ST_ALL : mtp_pkg::ST_PAIR;
			end
			mtp_pkg::ST_PAIR: begin
				div_req.start    = !div_run_q;
				div_req.dividend = pr_sum_q;
				div_req.divisor  = pr_cnt_q;
				if (div_done)
					state_d = (div_q_m != '0) ? mtp_pkg::ST_OUT : mtp_pkg::ST_ALL;
			end
			mtp_pkg::ST_ALL: begin
				div_req.start = !div_run_q;
				if (div_done)
					state_d = (kind_q == mtp_pkg::KIND_COMPLETE) ?
						mtp_pkg::ST_RECENT : mtp_pkg::ST_OUT;
			end
			// compare state against the registered overall average
			mtp_pkg::ST_RECENT: state_d = mtp_pkg::ST_OUT;
			mtp_pkg::ST_OUT: begin
				if (out_free)
					state_d = mtp_pkg::ST_IDLE;
			end
			default: state_d = mtp_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= mtp_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			en_q   <= 1'b1;
			base_q <= mtp_pkg::RST_BASE_MS;
			step_q <= mtp_pkg::RST_STEP_MS;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				mtp_pkg::CFG_ENABLE: en_q   <= cfg_data[0];
				mtp_pkg::CFG_BASE:   base_q <= cfg_data;
				mtp_pkg::CFG_STEP:   step_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// history bookkeeping and pending move
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q     <= '0;
			count_q  <= '0;
			inprog_q <= 1'b0;
			start_q  <= '0;
			pfrom_q  <= '0;
			pto_q    <= '0;
		end else if (accept) begin
			case (in_data.kind)
				mtp_pkg::KIND_START: begin
					if (en_q) begin
						start_q  <= in_data.time_ms;
						pfrom_q  <= in_data.from_slot;
						pto_q    <= in_data.to_slot;
						inprog_q <= 1'b1;
					end
				end
				mtp_pkg::KIND_COMPLETE: begin
					if (rec_ok) begin
						wp_q     <= wp_next;
						count_q  <= cnt_next;
						inprog_q <= 1'b0;
					end
				end
				mtp_pkg::KIND_CLEAR: begin
					wp_q     <= '0;
					count_q  <= '0;
					inprog_q <= 1'b0;
				end
				default: ;
			endcase
		end
	end

	// walk control and divider handshake
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1    <= 1'b0;
			div_run_q <= 1'b0;
			k_q       <= '0;
		end else begin
			vld_s1 <= issue;
			if (accept)
				k_q <= '0;
			else if (issue)
				k_q <= k_q + 1'b1;
			if (div_req.start)
				div_run_q <= 1'b1;
			else if (div_done)
				div_run_q <= 1'b0;
		end
	end

	// walk datapath: newest entry first, accumulate on the registered read data
	always_ff @(posedge clk) begin
		rec_s1 <= k_q < CW'(mtp_pkg::RECENT_N);
		if (accept) begin
			kind_q   <= in_data.kind;
			from_q   <= in_data.from_slot;
			to_q     <= in_data.to_slot;
			// a complete walks from the entry it just wrote
			rd_idx_q <= (in_data.kind == mtp_pkg::KIND_COMPLETE) ? wp_q : walk_first;
			ov_sum_q <= '0;
			ov_cnt_q <= '0;
			pr_sum_q <= '0;
			pr_cnt_q <= '0;
			rc_sum_q <= '0;
		end else begin
			if (issue)
				rd_idx_q <= (rd_idx_q == '0) ? AW'(mtp_pkg::HIST_DEPTH - 1) : rd_idx_q - 1'b1;
			if (vld_s1 && ram_rd.success) begin
				ov_sum_q <= ov_sum_q + SW'(ram_rd.duration);
				ov_cnt_q <= ov_cnt_q + 1'b1;
				if (rec_s1)
					rc_sum_q <= rc_sum_q + SW'(ram_rd.duration);
				if (ram_rd.from_slot == from_q && ram_rd.to_slot == to_q) begin
					pr_sum_q <= pr_sum_q + SW'(ram_rd.duration);
					pr_cnt_q <= pr_cnt_q + 1'b1;
				end
			end
		end
	end

	// result assembly for walked requests
	always_ff @(posedge clk) begin
		if (state_q == mtp_pkg::ST_WALK) begin
			res_q <= '{predicted_ms: '0, prediction_source: mtp_pkg::SRC_PAIR,
				recorded: (kind_q == mtp_pkg::KIND_COMPLETE), degraded: 1'b0,
				entries_held: 11'(count_q)};
		end else if (state_q == mtp_pkg::ST_RECENT) begin
			res_q.degraded <= rc_sum_q >= deg_thr;
		end else if (div_done) begin
			case (state_q)
				mtp_pkg::ST_PAIR: begin
					res_q.predicted_ms      <= div_q_m;
					res_q.prediction_source <= mtp_pkg::SRC_PAIR;
				end
				mtp_pkg::ST_ALL: begin
					ov_avg_q  <= div_q_m;
					ov_mod5_q <= ov_mod5;
					// a complete carries no prediction
					if (kind_q != mtp_pkg::KIND_COMPLETE) begin
						if (div_q_m != '0) begin
							res_q.predicted_ms      <= div_q_m;
							res_q.prediction_source <= mtp_pkg::SRC_OVERALL;
						end else begin
							res_q.predicted_ms      <= dflt_ms;
							res_q.prediction_source <= mtp_pkg::SRC_DEFAULT;
						end
					end
				end
				default: ;
			endcase
		end
	end

	// results for requests answered without a walk
	always_comb begin
		quick_res          = '0;
		quick_res.recorded = (in_data.kind == mtp_pkg::KIND_COMPLETE) && rec_ok;
		case (in_data.kind)
			mtp_pkg::KIND_COMPLETE:
				quick_res.entries_held = 11'(rec_ok ? cnt_next : count_q);
			mtp_pkg::KIND_CLEAR: quick_res.entries_held = '0;
			default: quick_res.entries_held = 11'(count_q);
		endcase
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept && state_d == mtp_pkg::ST_IDLE) begin
			out_valid_q <= 1'b1;
		end else if (state_q == mtp_pkg::ST_OUT && out_free) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && state_d == mtp_pkg::ST_IDLE) begin
			out_q <= quick_res;
		end else if (state_q == mtp_pkg::ST_OUT && out_free) begin
			out_q <= res_q;
		end
	end

endmodule

FILE: design/mtp_checker.sv
`include "move_time_profiler_defines.svh"

module mtp_checker (
	input logic          clk,
	input logic          arst_n,
	input logic          out_valid,
	input logic          out_stall,
	input mtp_pkg::out_t out_data
);

	`MTP_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && out_stall, out_valid, "result dropped while stalled")
	`MTP_ASSERT_NEXT(a_out_stable, clk, arst_n, out_valid && out_stall, $stable(out_data), "stalled result changed")
	`MTP_ASSERT_NOW(a_rec_no_pred, clk, arst_n, out_valid && out_data.recorded, out_data.predicted_ms == 32'd0, "recorded move carries a prediction")
	`MTP_ASSERT_NOW(a_deg_needs_hist, clk, arst_n, out_valid && out_data.degraded, out_data.recorded && (out_data.entries_held >= 11'(mtp_pkg::DEGRADE_MIN)), "degraded without enough history")

endmodule

bind move_time_profiler mtp_checker u_mtp_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.out_data  (out_data)
);
